### rtl/pbdt_pkg.sv
// ----------------------------------------------------------------------------
// pbdt_pkg
// Shared constants, codes and types of the product distance table block.
// ----------------------------------------------------------------------------
package pbdt_pkg;

  localparam int A_MAX      = 2048;
  localparam int B_MAX      = 512;
  localparam int MOVES_MAX  = 18;
  localparam int DIST_WIDTH = 5;

  localparam int A_W    = $clog2(A_MAX);
  localparam int B_W    = $clog2(B_MAX);
  localparam int NA_W   = $clog2(A_MAX + 1);
  localparam int NB_W   = $clog2(B_MAX + 1);
  localparam int M_W    = $clog2(MOVES_MAX + 1);
  localparam int TA_AW  = $clog2(A_MAX * MOVES_MAX);
  localparam int TB_AW  = $clog2(B_MAX * MOVES_MAX);
  localparam int D_AW   = A_W + B_W;
  localparam int CNT_W  = D_AW + 1;
  localparam int CFG_W  = 12;
  localparam int CIDX_W = 2;

  localparam logic [DIST_WIDTH-1:0] UNREACH     = {DIST_WIDTH{1'b1}};
  localparam logic [DIST_WIDTH-1:0] DEPTH_LIMIT = UNREACH - 1'b1;

  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_BUILD  = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic [1:0] STAT_LOAD_OK = 2'd0;
  localparam logic [1:0] STAT_READ    = 2'd1;
  localparam logic [1:0] STAT_DONE    = 2'd2;
  localparam logic [1:0] STAT_REJECT  = 2'd3;

  localparam logic [CIDX_W-1:0] REG_MOVES  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_A_SIZE = 2'd1;
  localparam logic [CIDX_W-1:0] REG_B_SIZE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_CLR,
    S_SEED,
    S_SCAN,
    S_SCAN_WAIT,
    S_MOVE_RD,
    S_MOVE_WAIT,
    S_CHK,
    S_ADV,
    S_DONE
  } state_e;

endpackage

### rtl/pbdt_ram.sv
// ----------------------------------------------------------------------------
// pbdt_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module pbdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/product_bfs_distance_table.sv
// ----------------------------------------------------------------------------
// product_bfs_distance_table
// Breadth-first distance table over pairs of two coordinates, built from two
// software-loaded move tables.
// ----------------------------------------------------------------------------
// Loads and reads take one word at a time. A load is accepted in any cycle in
// which the block is idle and the result register is free, and its result
// word is valid the cycle after it is accepted. A read holds off the next word
// in S_RD_WAIT for the distance memory read; its result word is registered
// there. A build first clears all 2^20 entries of the distance memory, one
// entry per cycle, then sweeps the pairs in use once per layer: each pair
// passes S_SCAN, S_SCAN_WAIT and S_ADV, and each move applied to a pair at the
// current depth passes S_MOVE_RD, S_MOVE_WAIT and S_CHK, but skips S_CHK when
// its destination is out of range. Only one word is in work at a time.
// Until the first build every pair reads as unreached.
module product_bfs_distance_table (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [pbdt_pkg::CIDX_W-1:0]            cfg_index_i,
  input  logic [pbdt_pkg::CFG_W-1:0]             cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             kind_i,
  input  logic [pbdt_pkg::A_W-1:0]               coord_a_i,
  input  logic [pbdt_pkg::B_W-1:0]               coord_b_i,
  input  logic [4:0]                             move_index_i,
  input  logic [pbdt_pkg::A_W-1:0]               next_state_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [1:0]                             status_o,
  output logic [pbdt_pkg::DIST_WIDTH-1:0]        distance_o,
  output logic                                   unreached_o,
  output logic [pbdt_pkg::DIST_WIDTH-1:0]        depth_reached_o,
  output logic [pbdt_pkg::CNT_W-1:0]             reached_count_o
);

  import pbdt_pkg::*;

  state_e state_q, state_d;

  logic [M_W-1:0]  moves_q;
  logic [NA_W-1:0] a_size_q;
  logic [NB_W-1:0] b_size_q;
  logic [NA_W-1:0] na;
  logic [NB_W-1:0] nb;
  logic [M_W-1:0]  nm;

  logic [A_W-1:0]        a_q, a_d;
  logic [B_W-1:0]        b_q, b_d;
  logic [M_W-1:0]        m_q, m_d;
  logic [D_AW-1:0]       clr_q, clr_d;
  logic [D_AW-1:0]       dst_q, dst_d;
  logic [DIST_WIDTH-1:0] depth_q, depth_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  added_q, added_d;
  logic                  built_q, built_d;
  logic                  rd_ok_q, rd_ok_d;

  logic                  out_valid_q, out_valid_d;
  logic [1:0]            status_q, status_d;
  logic [DIST_WIDTH-1:0] dist_q, dist_d;
  logic                  unr_q, unr_d;
  logic [DIST_WIDTH-1:0] odepth_q, odepth_d;
  logic [CNT_W-1:0]      ocount_q, ocount_d;

  logic                  out_free, in_acc;
  logic                  load_a_ok, load_b_ok, read_ok;
  logic                  b_last, a_last, dst_ok;

  logic                  ta_we, tb_we, d_we;
  logic [TA_AW-1:0]      ta_waddr, ta_raddr;
  logic [TB_AW-1:0]      tb_waddr, tb_raddr;
  logic [A_W-1:0]        ta_rdata;
  logic [B_W-1:0]        tb_rdata;
  logic [D_AW-1:0]       d_waddr, d_raddr;
  logic [DIST_WIDTH-1:0] d_wdata, d_rdata;

  always_comb begin
    if (a_size_q == '0) begin
      na = NA_W'(1);
    end else if (a_size_q > NA_W'(A_MAX)) begin
      na = NA_W'(A_MAX);
    end else begin
      na = a_size_q;
    end
    if (b_size_q == '0) begin
      nb = NB_W'(1);
    end else if (b_size_q > NB_W'(B_MAX)) begin
      nb = NB_W'(B_MAX);
    end else begin
      nb = b_size_q;
    end
    nm = (moves_q > M_W'(MOVES_MAX)) ? M_W'(MOVES_MAX) : moves_q;
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign load_a_ok = (32'(coord_a_i) < 32'(na)) && (32'(next_state_i) < 32'(na)) &&
                     (32'(move_index_i) < 32'(nm));
  assign load_b_ok = (32'(coord_b_i) < 32'(nb)) && (32'(next_state_i) < 32'(nb)) &&
                     (32'(move_index_i) < 32'(nm));
  assign read_ok   = (32'(coord_a_i) < 32'(na)) && (32'(coord_b_i) < 32'(nb));
  assign b_last    = (32'(b_q) + 32'd1) >= 32'(nb);
  assign a_last    = (32'(a_q) + 32'd1) >= 32'(na);
  assign dst_ok    = (32'(ta_rdata) < 32'(na)) && (32'(tb_rdata) < 32'(nb));

  assign ta_we    = in_acc && (kind_i == KIND_LOAD_A) && load_a_ok;
  assign tb_we    = in_acc && (kind_i == KIND_LOAD_B) && load_b_ok;
  assign ta_waddr = TA_AW'(coord_a_i) * TA_AW'(MOVES_MAX) + TA_AW'(move_index_i);
  assign tb_waddr = TB_AW'(coord_b_i) * TB_AW'(MOVES_MAX) + TB_AW'(move_index_i);
  assign ta_raddr = TA_AW'(a_q) * TA_AW'(MOVES_MAX) + TA_AW'(m_q);
  assign tb_raddr = TB_AW'(b_q) * TB_AW'(MOVES_MAX) + TB_AW'(m_q);

  pbdt_ram #(.WIDTH(A_W), .DEPTH(A_MAX * MOVES_MAX)) u_table_a (
    .clk_i   (clk_i),
    .we_i    (ta_we),
    .waddr_i (ta_waddr),
    .wdata_i (next_state_i),
    .raddr_i (ta_raddr),
    .rdata_o (ta_rdata)
  );

  pbdt_ram #(.WIDTH(B_W), .DEPTH(B_MAX * MOVES_MAX)) u_table_b (
    .clk_i   (clk_i),
    .we_i    (tb_we),
    .waddr_i (tb_waddr),
    .wdata_i (next_state_i[B_W-1:0]),
    .raddr_i (tb_raddr),
    .rdata_o (tb_rdata)
  );

  pbdt_ram #(.WIDTH(DIST_WIDTH), .DEPTH(A_MAX * B_MAX)) u_dist (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (kind_i == KIND_BUILD)) begin
          state_d = S_CLR;
        end else if (in_acc && (kind_i == KIND_READ)) begin
          state_d = S_RD_WAIT;
        end
      end
      S_RD_WAIT:   state_d = S_IDLE;
      S_CLR:       state_d = (&clr_q) ? S_SEED : S_CLR;
      S_SEED:      state_d = S_SCAN;
      S_SCAN:      state_d = S_SCAN_WAIT;
      S_SCAN_WAIT: state_d = (d_rdata == depth_q) ? S_MOVE_RD : S_ADV;
      S_MOVE_RD:   state_d = (m_q < nm) ? S_MOVE_WAIT : S_ADV;
      S_MOVE_WAIT: state_d = dst_ok ? S_CHK : S_MOVE_RD;
      S_CHK:       state_d = S_MOVE_RD;
      S_ADV: begin
        if (!b_last || !a_last) begin
          state_d = S_SCAN;
        end else if (added_q && ((depth_q + 1'b1) < DEPTH_LIMIT)) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE:      state_d = out_free ? S_IDLE : S_DONE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    a_d         = a_q;
    b_d         = b_q;
    m_d         = m_q;
    clr_d       = clr_q;
    dst_d       = dst_q;
    depth_d     = depth_q;
    count_d     = count_q;
    added_d     = added_q;
    built_d     = built_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    dist_d      = dist_q;
    unr_d       = unr_q;
    odepth_d    = odepth_q;
    ocount_d    = ocount_q;
    d_we        = 1'b0;
    d_waddr     = clr_q;
    d_wdata     = UNREACH;
    d_raddr     = {a_q, b_q};
    unique case (state_q)
      S_IDLE: begin
        d_raddr = {coord_a_i, coord_b_i};
        rd_ok_d = read_ok;
        if (in_acc && ((kind_i == KIND_LOAD_A) || (kind_i == KIND_LOAD_B))) begin
          out_valid_d = 1'b1;
          status_d    = ((kind_i == KIND_LOAD_A) ? load_a_ok : load_b_ok) ?
                        STAT_LOAD_OK : STAT_REJECT;
          dist_d      = '0;
          unr_d       = 1'b0;
          odepth_d    = depth_q;
          ocount_d    = count_q;
        end
        if (in_acc && (kind_i == KIND_BUILD)) begin
          clr_d = '0;
        end
      end
      S_RD_WAIT: begin
        out_valid_d = 1'b1;
        status_d    = rd_ok_q ? STAT_READ : STAT_REJECT;
        dist_d      = (rd_ok_q && built_q) ? d_rdata : UNREACH;
        unr_d       = !(rd_ok_q && built_q) || (d_rdata == UNREACH);
        odepth_d    = depth_q;
        ocount_d    = count_q;
      end
      S_CLR: begin
        d_we  = 1'b1;
        clr_d = clr_q + 1'b1;
      end
      S_SEED: begin
        d_we    = 1'b1;
        d_waddr = '0;
        d_wdata = '0;
        count_d = CNT_W'(1);
        depth_d = '0;
        added_d = 1'b0;
        built_d = 1'b1;
        a_d     = '0;
        b_d     = '0;
      end
      S_SCAN: begin
      end
      S_SCAN_WAIT: begin
        m_d = '0;
      end
      S_MOVE_RD: begin
      end
      S_MOVE_WAIT: begin
        dst_d   = {ta_rdata, tb_rdata};
        d_raddr = {ta_rdata, tb_rdata};
        if (!dst_ok) begin
          m_d = m_q + 1'b1;
        end
      end
      S_CHK: begin
        m_d = m_q + 1'b1;
        if (d_rdata == UNREACH) begin
          d_we    = 1'b1;
          d_waddr = dst_q;
          d_wdata = depth_q + 1'b1;
          count_d = count_q + 1'b1;
          added_d = 1'b1;
        end
      end
      S_ADV: begin
        if (!b_last) begin
          b_d = b_q + 1'b1;
        end else begin
          b_d = '0;
          if (!a_last) begin
            a_d = a_q + 1'b1;
          end else begin
            a_d     = '0;
            added_d = 1'b0;
            if (added_q) begin
              depth_d = depth_q + 1'b1;
            end
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = STAT_DONE;
          dist_d      = '0;
          unr_d       = 1'b0;
          odepth_d    = depth_q;
          ocount_d    = count_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      moves_q     <= M_W'(MOVES_MAX);
      a_size_q    <= NA_W'(2048);
      b_size_q    <= NB_W'(495);
      depth_q     <= '0;
      count_q     <= '0;
      added_q     <= 1'b0;
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      m_q         <= '0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      count_q     <= count_d;
      added_q     <= added_d;
      built_q     <= built_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
      a_q         <= a_d;
      b_q         <= b_d;
      m_q         <= m_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_MOVES:  moves_q  <= cfg_wdata_i[M_W-1:0];
          REG_A_SIZE: a_size_q <= cfg_wdata_i[NA_W-1:0];
          REG_B_SIZE: b_size_q <= cfg_wdata_i[NB_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dst_q    <= dst_d;
    rd_ok_q  <= rd_ok_d;
    status_q <= status_d;
    dist_q   <= dist_d;
    unr_q    <= unr_d;
    odepth_q <= odepth_d;
    ocount_q <= ocount_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign distance_o      = dist_q;
  assign unreached_o     = unr_q;
  assign depth_reached_o = odepth_q;
  assign reached_count_o = ocount_q;

`ifndef SYNTHESIS
  a_accept_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (state_q == S_IDLE))
    else $error("word accepted while busy");

  a_depth_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_LIMIT)
    else $error("depth beyond limit");

  a_mark_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_we && (state_q == S_CHK)) |-> (d_wdata == depth_q + 1'b1))
    else $error("pair marked at wrong depth");

  a_count_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SEED) |=> (count_q >= $past(count_q)))
    else $error("reached count decreased");
`endif

endmodule
